@@ sv/bfd_pkg.sv @@
// Shared types, widths and constant tables for the box filter downscaler.
// No dependencies; every other file but bfd_fifo imports this package.
`default_nettype none

package bfd_pkg;

  // Fixed field widths
  localparam int PIX_W      = 8;
  localparam int SUM_W      = 14;
  localparam int CFG_W      = 11;
  localparam int DIVREG_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int MAX_HEIGHT = 1024;
  localparam int HT_W       = 11;
  localparam int DIDX_W     = 5;

  // Reciprocals: ceil(2^16 / d) for sizes, ceil(2^22 / d^2) for the block area
  localparam int RCP1_SHIFT = 16;
  localparam int RCP1_W     = 17;
  localparam int RCP2_SHIFT = 22;
  localparam int RCP2_W     = 23;
  localparam int PROD_W     = SUM_W + RCP2_W;

  // Reset values of the registers
  localparam logic [DIVREG_W-1:0] DIVISOR_RST = 4'd1;
  localparam logic [CFG_W-1:0]    SIZE_RST    = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIVISOR    = 2'd0,
    REG_SRC_WIDTH  = 2'd1,
    REG_SRC_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [SUM_W-1:0] blue;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] red;
  } rgb_sum_t;

  // Flags carried with each closed row segment of a block
  typedef struct packed {
    logic ok;    // column index lies inside the accumulator store
    logic acc;   // add the stored column sum
    logic emit;  // bottom row of the block: give a pixel
    logic last;  // last output pixel of the frame
  } op_ctl_t;

  function automatic logic [RCP1_W-1:0] rcp_div(input logic [DIDX_W-1:0] d);
    logic [RCP1_W-1:0] r;
    case (d)
      5'd2:    r = 17'd32768;
      5'd3:    r = 17'd21846;
      5'd4:    r = 17'd16384;
      5'd5:    r = 17'd13108;
      5'd6:    r = 17'd10923;
      5'd7:    r = 17'd9363;
      5'd8:    r = 17'd8192;
      5'd9:    r = 17'd7282;
      5'd10:   r = 17'd6554;
      5'd11:   r = 17'd5958;
      5'd12:   r = 17'd5462;
      5'd13:   r = 17'd5042;
      5'd14:   r = 17'd4682;
      5'd15:   r = 17'd4370;
      5'd16:   r = 17'd4096;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  function automatic logic [RCP2_W-1:0] rcp_area(input logic [DIDX_W-1:0] d);
    logic [RCP2_W-1:0] r;
    case (d)
      5'd2:    r = 23'd1048576;
      5'd3:    r = 23'd466034;
      5'd4:    r = 23'd262144;
      5'd5:    r = 23'd167773;
      5'd6:    r = 23'd116509;
      5'd7:    r = 23'd85599;
      5'd8:    r = 23'd65536;
      5'd9:    r = 23'd51782;
      5'd10:   r = 23'd41944;
      5'd11:   r = 23'd34664;
      5'd12:   r = 23'd29128;
      5'd13:   r = 23'd24819;
      5'd14:   r = 23'd21400;
      5'd15:   r = 23'd18642;
      5'd16:   r = 23'd16384;
      default: r = 23'd4194304;
    endcase
    return r;
  endfunction

  // Take the quotient from the scaled product and clip to the pixel range
  function automatic logic [PIX_W-1:0] sat_avg(input logic [PROD_W-1:0] prod);
    logic [PROD_W-RCP2_SHIFT-1:0] q;
    q = prod[PROD_W-1:RCP2_SHIFT];
    if (q > (PROD_W-RCP2_SHIFT)'(255)) begin
      return 8'hFF;
    end
    return q[PIX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/bfd_cfg.sv @@
// Configuration registers and the block geometry derived from them.
// Depends on bfd_pkg (register codes, reciprocal table).
`default_nettype none

module bfd_cfg #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_DIVISOR = 8
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire  [bfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [bfd_pkg::CFG_W-1:0]       cfg_data,
  output logic [$clog2(MAX_DIVISOR+1)-1:0] d,
  output logic [$clog2(MAX_WIDTH+1)-1:0]  w,
  output logic [bfd_pkg::HT_W-1:0]        h,
  output logic [$clog2(MAX_WIDTH+1)-1:0]  ow,
  output logic [bfd_pkg::HT_W-1:0]        oh,
  output logic [$clog2(MAX_WIDTH+1)-1:0]  owd,
  output logic [bfd_pkg::HT_W-1:0]        ohd,
  output logic [$clog2(MAX_WIDTH+1)-1:0]  owm1,
  output logic [bfd_pkg::HT_W-1:0]        ohdm1,
  output logic                            ready
);
  import bfd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int DW = $clog2(MAX_DIVISOR + 1);

  logic [DIVREG_W-1:0] div_r;
  logic [CFG_W-1:0]    wid_r, hgt_r;
  logic [1:0]          settle_r;
  logic [DW-1:0]       d_cl, d_r;
  logic [CW-1:0]       w_cl, w_r, ow_r, owd_r, owm1_r;
  logic [HT_W-1:0]     h_cl, h_r, oh_r, ohd_r, ohdm1_r;
  logic [CW+RCP1_W-1:0]   ow_prod;
  logic [HT_W+RCP1_W-1:0] oh_prod;
  logic [CW+DW-1:0]       owd_prod;
  logic [HT_W+DW-1:0]     ohd_prod;

  // Take register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r    <= DIVISOR_RST;
      wid_r    <= SIZE_RST;
      hgt_r    <= SIZE_RST;
      settle_r <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DIVISOR:    div_r <= cfg_data[DIVREG_W-1:0];
        REG_SRC_WIDTH:  wid_r <= cfg_data;
        REG_SRC_HEIGHT: hgt_r <= cfg_data;
        default: ;
      endcase
      settle_r <= 2'd3;
    end else if (settle_r != 2'd0) begin
      settle_r <= settle_r - 2'd1;
    end
  end

  // Clamp zero to one and large values to the supported bound
  always_comb begin
    if (div_r == '0) begin
      d_cl = DW'(1);
    end else if (int'(div_r) > MAX_DIVISOR) begin
      d_cl = DW'(MAX_DIVISOR);
    end else begin
      d_cl = DW'(div_r);
    end
    if (wid_r == '0) begin
      w_cl = CW'(1);
    end else if (int'(wid_r) > MAX_WIDTH) begin
      w_cl = CW'(MAX_WIDTH);
    end else begin
      w_cl = CW'(wid_r);
    end
    if (hgt_r == '0) begin
      h_cl = HT_W'(1);
    end else if (int'(hgt_r) > MAX_HEIGHT) begin
      h_cl = HT_W'(MAX_HEIGHT);
    end else begin
      h_cl = hgt_r;
    end
  end

  assign ow_prod  = {{RCP1_W{1'b0}}, w_r} * {{CW{1'b0}}, rcp_div(DIDX_W'(d_r))};
  assign oh_prod  = {{RCP1_W{1'b0}}, h_r} * {{HT_W{1'b0}}, rcp_div(DIDX_W'(d_r))};
  assign owd_prod = {{DW{1'b0}}, ow_r} * {{CW{1'b0}}, d_r};
  assign ohd_prod = {{DW{1'b0}}, oh_r} * {{HT_W{1'b0}}, d_r};

  // Derive output size and whole-block extent over three register stages
  always_ff @(posedge clk) begin
    d_r     <= d_cl;
    w_r     <= w_cl;
    h_r     <= h_cl;
    ow_r    <= CW'(ow_prod >> RCP1_SHIFT);
    oh_r    <= HT_W'(oh_prod >> RCP1_SHIFT);
    owd_r   <= CW'(owd_prod);
    ohd_r   <= HT_W'(ohd_prod);
    owm1_r  <= ow_r - CW'(1);
    ohdm1_r <= HT_W'(ohd_prod) - HT_W'(1);
  end

  assign d     = d_r;
  assign w     = w_r;
  assign h     = h_r;
  assign ow    = ow_r;
  assign oh    = oh_r;
  assign owd   = owd_r;
  assign ohd   = ohd_r;
  assign owm1  = owm1_r;
  assign ohdm1 = ohdm1_r;
  assign ready = (settle_r == 2'd0);

endmodule

`default_nettype wire

@@ sv/bfd_front.sv @@
// Front end: takes source pixels, tracks raster and block position and
// sums each block's row segment. Depends on bfd_pkg.
`default_nettype none

module bfd_front #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_DIVISOR = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  input  wire  [3*bfd_pkg::PIX_W-1:0]      in_tdata,
  input  wire                              in_tuser,
  input  wire  [$clog2(MAX_DIVISOR+1)-1:0] d,
  input  wire  [$clog2(MAX_WIDTH+1)-1:0]   w,
  input  wire  [bfd_pkg::HT_W-1:0]         h,
  input  wire  [$clog2(MAX_WIDTH+1)-1:0]   ow,
  input  wire  [bfd_pkg::HT_W-1:0]         oh,
  input  wire  [$clog2(MAX_WIDTH+1)-1:0]   owd,
  input  wire  [bfd_pkg::HT_W-1:0]         ohd,
  input  wire  [$clog2(MAX_WIDTH+1)-1:0]   owm1,
  input  wire  [bfd_pkg::HT_W-1:0]         ohdm1,
  input  wire                              cfg_ready,
  input  wire                              q_full,
  output logic                             push,
  output bfd_pkg::rgb_sum_t                push_sum,
  output bfd_pkg::op_ctl_t                 push_ctl,
  output logic [$clog2(MAX_WIDTH)-1:0]     push_addr
);
  import bfd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int DW = $clog2(MAX_DIVISOR + 1);
  localparam int AW = $clog2(MAX_WIDTH);

  logic [CW-1:0]   col_r, col_nxt, oc_r, oc_nxt, col_e, oc_e, col_inc;
  logic [HT_W-1:0] row_r, row_nxt, row_e, row_inc;
  logic [DW-1:0]   px_r, px_nxt, py_r, py_nxt, px_e, py_e;
  rgb_sum_t        rps_r, rps_nxt, rps_e, base, psum;
  logic            accept, in_rows, active, close, row_end;

  assign in_tready = cfg_ready && !q_full;
  assign accept    = in_tvalid && in_tready;

  // Frame start restarts the position
  assign col_e = in_tuser ? '0 : col_r;
  assign row_e = in_tuser ? '0 : row_r;
  assign px_e  = in_tuser ? '0 : px_r;
  assign py_e  = in_tuser ? '0 : py_r;
  assign oc_e  = in_tuser ? '0 : oc_r;
  assign rps_e = in_tuser ? '0 : rps_r;

  // Classify the pixel against the whole-block area
  assign in_rows = (oh != '0) && (row_e < ohd);
  assign active  = in_rows && (ow != '0) && (col_e < owd);
  assign close   = active && (px_e >= d - DW'(1));
  assign col_inc = col_e + CW'(1);
  assign row_inc = row_e + HT_W'(1);
  assign row_end = (col_inc >= w);

  // Add the pixel to the row segment
  assign base       = (px_e != '0) ? rps_e : '0;
  assign psum.red   = base.red   + SUM_W'(in_tdata[PIX_W-1:0]);
  assign psum.green = base.green + SUM_W'(in_tdata[2*PIX_W-1:PIX_W]);
  assign psum.blue  = base.blue  + SUM_W'(in_tdata[3*PIX_W-1:2*PIX_W]);

  // Hand a closed segment to the back end
  assign push          = accept && close;
  assign push_sum      = psum;
  assign push_ctl.ok   = (oc_e < CW'(MAX_WIDTH));
  assign push_ctl.acc  = (py_e != '0);
  assign push_ctl.emit = (py_e >= d - DW'(1));
  assign push_ctl.last = (oc_e >= owm1) && (row_e >= ohdm1);
  assign push_addr     = oc_e[AW-1:0];

  // Advance the position counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    px_nxt  = px_r;
    py_nxt  = py_r;
    oc_nxt  = oc_r;
    rps_nxt = rps_r;
    if (accept) begin
      col_nxt = col_inc;
      row_nxt = row_e;
      px_nxt  = px_e;
      py_nxt  = py_e;
      oc_nxt  = oc_e;
      rps_nxt = rps_e;
      if (active) begin
        rps_nxt = psum;
        if (close) begin
          oc_nxt  = oc_e + CW'(1);
          px_nxt  = '0;
          rps_nxt = '0;
        end else begin
          px_nxt = px_e + DW'(1);
        end
      end
      if (row_end) begin
        col_nxt = '0;
        oc_nxt  = '0;
        px_nxt  = '0;
        rps_nxt = '0;
        if (in_rows) begin
          py_nxt = (py_e >= d - DW'(1)) ? '0 : py_e + DW'(1);
        end
        row_nxt = row_inc;
        if (row_inc >= h) begin
          row_nxt = '0;
          py_nxt  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      px_r  <= '0;
      py_r  <= '0;
      oc_r  <= '0;
      rps_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      px_r  <= px_nxt;
      py_r  <= py_nxt;
      oc_r  <= oc_nxt;
      rps_r <= rps_nxt;
    end
  end

endmodule

`default_nettype wire

@@ sv/bfd_fifo.sv @@
// Four-entry queue between the front and back ends.
// Does not import bfd_pkg; width is a parameter.
`default_nettype none

module bfd_fifo #(
  parameter int W = 64
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          push,
  input  wire  [W-1:0] push_data,
  input  wire          pop,
  output logic [W-1:0] head,
  output logic         empty,
  output logic         full
);
  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == (PW+1)'(DEPTH));
  assign head  = slot_r[rd_ptr_r];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (PW+1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/bfd_back.sv @@
// Back end: per-column accumulator store, block sum and area division,
// result register. Depends on bfd_pkg (sum types, reciprocal table).
`default_nettype none

module bfd_back #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_DIVISOR = 8
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire  [$clog2(MAX_DIVISOR+1)-1:0] d,
  input  wire                              q_empty,
  input  bfd_pkg::rgb_sum_t                q_sum,
  input  bfd_pkg::op_ctl_t                 q_ctl,
  input  wire  [$clog2(MAX_WIDTH)-1:0]     q_addr,
  output logic                             pop,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  output logic [3*bfd_pkg::PIX_W-1:0]      out_tdata,
  output logic                             out_tlast
);
  import bfd_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  rgb_sum_t           col_mem [MAX_WIDTH];
  rgb_sum_t           rd_r, byp_d_r, a_sum_r, prev, sum_a;
  op_ctl_t            a_ctl_r;
  logic [AW-1:0]      a_addr_r;
  logic               a_v_r, byp_hit_r, b_v_r, b_last_r, out_v_r, out_last_r;
  logic [PROD_W-1:0]  b_pr_r, b_pg_r, b_pb_r;
  logic [PIX_W-1:0]   out_r_r, out_g_r, out_b_r;
  logic [RCP2_W-1:0]  rcp;
  logic               adv, wr_en;

  assign adv   = !out_v_r || out_tready;
  assign pop   = adv && !q_empty;
  assign wr_en = adv && a_v_r && a_ctl_r.ok;
  assign rcp   = rcp_area(DIDX_W'(d));

  // Column sum from the store, or from the write just made to the same column
  always_comb begin
    prev = byp_hit_r ? byp_d_r : rd_r;
    if (!a_ctl_r.ok) begin
      prev = '0;
    end
    sum_a = a_sum_r;
    if (a_ctl_r.acc) begin
      sum_a.red   = a_sum_r.red   + prev.red;
      sum_a.green = a_sum_r.green + prev.green;
      sum_a.blue  = a_sum_r.blue  + prev.blue;
    end
  end

  // Accumulator store: write the updated column, read the next request's column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      col_mem[a_addr_r] <= sum_a;
    end
    if (pop) begin
      rd_r <= col_mem[q_addr];
    end
  end

  // Payload of the pipeline stages
  always_ff @(posedge clk) begin
    if (adv) begin
      a_sum_r  <= q_sum;
      a_ctl_r  <= q_ctl;
      a_addr_r <= q_addr;
      byp_d_r  <= sum_a;
      b_pr_r   <= {{RCP2_W{1'b0}}, sum_a.red}   * {{SUM_W{1'b0}}, rcp};
      b_pg_r   <= {{RCP2_W{1'b0}}, sum_a.green} * {{SUM_W{1'b0}}, rcp};
      b_pb_r   <= {{RCP2_W{1'b0}}, sum_a.blue}  * {{SUM_W{1'b0}}, rcp};
      b_last_r <= a_ctl_r.last;
      if (b_v_r) begin
        out_r_r    <= sat_avg(b_pr_r);
        out_g_r    <= sat_avg(b_pg_r);
        out_b_r    <= sat_avg(b_pb_r);
        out_last_r <= b_last_r;
      end
    end
  end

  // Stage valids; hold everything while the result waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r     <= 1'b0;
      byp_hit_r <= 1'b0;
      b_v_r     <= 1'b0;
      out_v_r   <= 1'b0;
    end else if (adv) begin
      a_v_r     <= pop;
      byp_hit_r <= pop && wr_en && (a_addr_r == q_addr);
      b_v_r     <= a_v_r && a_ctl_r.emit;
      out_v_r   <= b_v_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_b_r, out_g_r, out_r_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

@@ sv/box_filter_downscaler.sv @@
// Box filter downscaler top level: configuration, front end, queue, back end.
// Depends on bfd_pkg, bfd_cfg, bfd_front, bfd_fifo and bfd_back.
//
// Averages each divisor x divisor block of RGB888 raster pixels into one
// output pixel (channel sums divided by the block area, truncated). Pixels
// outside the last whole block column or row are dropped. The input takes
// one pixel per clock; the sum that closes a block passes through the queue,
// the store read stage, the product register and the result register, and
// results are taken at one per clock. The input stalls only when the
// four-entry queue to the accumulator store is full (the output is held
// back) and after each register write while the block geometry is recomputed;
// it is also low after reset. The per-column store is one read and one write
// per clock, with forwarding for back-to-back updates of one column.
`default_nettype none

module box_filter_downscaler #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_DIVISOR = 8
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // pixel input
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire  [3*bfd_pkg::PIX_W-1:0]    in_tdata,   // red, green, blue
  input  wire                            in_tuser,   // frame_start
  // block average output
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [3*bfd_pkg::PIX_W-1:0]    out_tdata,  // out_red, out_green, out_blue
  output logic                           out_tlast,  // frame_end
  // register writes
  input  wire                            cfg_we,
  input  wire  [bfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [bfd_pkg::CFG_W-1:0]      cfg_data
);
  import bfd_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int DW  = $clog2(MAX_DIVISOR + 1);
  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int QW  = AW + $bits(op_ctl_t) + $bits(rgb_sum_t);

  logic [DW-1:0]   d;
  logic [CW-1:0]   w, ow, owd, owm1;
  logic [HT_W-1:0] h, oh, ohd, ohdm1;
  logic            cfg_ready, q_full, q_empty, push, pop;
  rgb_sum_t        push_sum, q_sum;
  op_ctl_t         push_ctl, q_ctl;
  logic [AW-1:0]   push_addr, q_addr;
  logic [QW-1:0]   q_head;

  bfd_cfg #(.MAX_WIDTH(MAX_WIDTH), .MAX_DIVISOR(MAX_DIVISOR)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .d         (d),
    .w         (w),
    .h         (h),
    .ow        (ow),
    .oh        (oh),
    .owd       (owd),
    .ohd       (ohd),
    .owm1      (owm1),
    .ohdm1     (ohdm1),
    .ready     (cfg_ready)
  );

  bfd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_DIVISOR(MAX_DIVISOR)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .d         (d),
    .w         (w),
    .h         (h),
    .ow        (ow),
    .oh        (oh),
    .owd       (owd),
    .ohd       (ohd),
    .owm1      (owm1),
    .ohdm1     (ohdm1),
    .cfg_ready (cfg_ready),
    .q_full    (q_full),
    .push      (push),
    .push_sum  (push_sum),
    .push_ctl  (push_ctl),
    .push_addr (push_addr)
  );

  bfd_fifo #(.W(QW)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_addr, push_ctl, push_sum}),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // Unpack the queue head
  assign q_sum  = q_head[$bits(rgb_sum_t)-1:0];
  assign q_ctl  = q_head[$bits(rgb_sum_t) +: $bits(op_ctl_t)];
  assign q_addr = q_head[QW-1 -: AW];

  bfd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_DIVISOR(MAX_DIVISOR)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .d          (d),
    .q_empty    (q_empty),
    .q_sum      (q_sum),
    .q_ctl      (q_ctl),
    .q_addr     (q_addr),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
